@@ hw/rtl/rabin_pkg.sv @@
// rabin engine package: types, constants, state encoding
package rabin_pkg;
  localparam int PRIME_BITS_DEF = 32;
  localparam int VAL_W = 64;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_P = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_Q = 1'b1;
  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_BAD = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [63:0] value_in;
  } in_req_t;

  typedef struct packed {
    logic [63:0] value_out;
    logic [1:0]  root_index;
    logic        last;
    logic        status;
  } out_req_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_MULN, OP_REDC, OP_MODMUL, OP_INVP, OP_INVQ,
    OP_POWP, OP_POWQ, OP_CRT1, OP_CRT2, OP_ROOTS
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_WAIT, S_EMIT, S_HOLD
  } state_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic bad;
  } dp_sts_t;
endpackage

@@ hw/rtl/rabin_dp.sv @@
// rabin datapath: shift-add modular multiplier, divider, euclid, sequencing regs
module rabin_dp import rabin_pkg::*; #(
  parameter int PRIME_BITS = PRIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o,
  input  logic [PRIME_BITS-1:0] p_i,
  input  logic [PRIME_BITS-1:0] q_i,
  input  logic [63:0]           val_i,
  input  logic [1:0]            sel_i,
  output logic [63:0]           res_o
);
  localparam int PB = PRIME_BITS;
  localparam int NB = 2*PRIME_BITS;

  // sub-step engines: modmul (bit-serial) and div (restoring)
  logic [NB-1:0] n_r, m_r, a_r, b_r, acc_r;
  logic [6:0]    cnt_r;
  logic [NB-1:0] r1_r, r3_r, mp_r, mq_r, yp_r, yq_r, c_r, t1_r;
  // running base of the modular power
  logic [NB-1:0] base_r;
  // euclid regs
  logic [PB-1:0] ex_r, ey_r, ec0_r, ec1_r;
  logic [NB:0]   drem_r;
  logic [NB-1:0] dq_r;
  logic [2:0]    phase_r;
  logic [PB:0]   pe_r;
  logic          busy_r, done_r, bad_r, pinv_r;
  op_t           op_r;

  function automatic logic [NB-1:0] addm(input logic [NB-1:0] x, y, m);
    logic [NB:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[NB-1:0];
  endfunction

  function automatic logic [NB-1:0] negm(input logic [NB-1:0] x, m);
    return (x == '0) ? '0 : m - x;
  endfunction

  logic [NB-1:0] n_w;
  assign n_w = NB'(p_i) * NB'(q_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; bad_r <= 1'b0; phase_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd_i.start && !busy_r) begin
        busy_r <= 1'b1; op_r <= cmd_i.op; phase_r <= '0; bad_r <= 1'b0;
        n_r <= n_w;
      end else if (busy_r) begin
        unique case (op_r)
          // n = p*q already; reduce the full 64-bit value mod n via restoring division
          OP_REDC: begin
            if (phase_r == 3'd0) begin
              drem_r <= '0; cnt_r <= 7'(VAL_W); phase_r <= 3'd1;
              if (n_r == '0) begin bad_r <= 1'b1; busy_r <= 1'b0; done_r <= 1'b1; end
            end else if (cnt_r != 0) begin
              logic [NB:0] t;
              t = {drem_r[NB-1:0], val_i[6'(cnt_r - 7'd1)]};
              if (t >= {1'b0, n_r}) drem_r <= t - {1'b0, n_r}; else drem_r <= t;
              cnt_r <= cnt_r - 7'd1;
            end else begin
              c_r <= drem_r[NB-1:0]; busy_r <= 1'b0; done_r <= 1'b1;
            end
          end
          // c*c mod n (encrypt)
          OP_MULN: begin
            if (phase_r == 3'd0) begin
              a_r <= c_r; b_r <= c_r; m_r <= n_r; acc_r <= '0; cnt_r <= 7'(NB);
              phase_r <= 3'd1;
            end else if (cnt_r != 0) begin
              logic [NB-1:0] t;
              t = addm(acc_r, acc_r, m_r);
              if (b_r[NB-1]) t = addm(t, a_r, m_r);
              acc_r <= t; b_r <= {b_r[NB-2:0], 1'b0}; cnt_r <= cnt_r - 7'd1;
            end else begin
              r1_r <= acc_r; busy_r <= 1'b0; done_r <= 1'b1;
            end
          end
          // extended euclid: INVP gives yp = p^-1 mod q, INVQ gives yq = q^-1 mod p
          OP_INVP, OP_INVQ: begin
            logic [PB-1:0] aa, mm;
            aa = (op_r == OP_INVP) ? p_i : q_i;
            mm = (op_r == OP_INVP) ? q_i : p_i;
            unique case (phase_r)
              3'd0: begin
                // x = a % m
                drem_r <= '0; dq_r <= NB'(aa) << PB; cnt_r <= 7'(PB); phase_r <= 3'd1;
                ey_r <= mm; ec0_r <= (mm == PB'(1)) ? '0 : PB'(1); ec1_r <= '0;
              end
              3'd1: begin
                if (cnt_r != 0) begin
                  logic [NB:0] t;
                  t = {drem_r[NB-1:0], dq_r[NB-1]};
                  dq_r <= {dq_r[NB-2:0], 1'b0};
                  if (t >= (NB+1)'(mm)) drem_r <= t - (NB+1)'(mm); else drem_r <= t;
                  cnt_r <= cnt_r - 7'd1;
                end else begin
                  ex_r <= drem_r[PB-1:0]; phase_r <= 3'd2;
                end
              end
              3'd2: begin
                if (ey_r == '0) begin
                  if (op_r == OP_INVP) yp_r <= NB'(ec0_r); else yq_r <= NB'(ec0_r);
                  bad_r <= (ex_r != PB'(1)); busy_r <= 1'b0; done_r <= 1'b1;
                end else begin
                  // quo, rem = x / y
                  drem_r <= '0; dq_r <= NB'(ex_r) << PB; cnt_r <= 7'(PB); phase_r <= 3'd3;
                end
              end
              3'd3: begin
                if (cnt_r != 0) begin
                  logic [NB:0] t;
                  t = {drem_r[NB-1:0], dq_r[NB-1]};
                  if (t >= (NB+1)'(ey_r)) begin
                    drem_r <= t - (NB+1)'(ey_r); dq_r <= {dq_r[NB-2:0], 1'b1};
                  end else begin
                    drem_r <= t; dq_r <= {dq_r[NB-2:0], 1'b0};
                  end
                  cnt_r <= cnt_r - 7'd1;
                end else begin
                  // (quo*c1) mod m via modmul; quo < m not guaranteed, so its bits go through the mod-m doubling chain
                  a_r <= NB'(ec1_r); b_r <= NB'(dq_r[PB-1:0]) << PB;
                  m_r <= NB'(mm); acc_r <= '0; cnt_r <= 7'(PB); phase_r <= 3'd4;
                  ex_r <= ey_r; ey_r <= drem_r[PB-1:0];
                end
              end
              default: begin
                if (cnt_r != 0) begin
                  logic [NB-1:0] t;
                  // quo may exceed m: feed bits into doubling chain, all mod m
                  t = addm(acc_r, acc_r, m_r);
                  if (b_r[NB-1]) t = addm(t, addm(a_r, '0, m_r), m_r);
                  acc_r <= t; b_r <= {b_r[NB-2:0], 1'b0}; cnt_r <= cnt_r - 7'd1;
                end else begin
                  ec0_r <= ec1_r;
                  ec1_r <= PB'(negm(acc_r, m_r) == m_r ? '0 :
                           addm(NB'(ec0_r), negm(acc_r, m_r), m_r));
                  phase_r <= 3'd2;
                end
              end
            endcase
          end
          // mp = c^((p+1)/4) mod p, mq likewise
          OP_POWP, OP_POWQ: begin
            logic [PB-1:0] mm;
            mm = (op_r == OP_POWP) ? p_i : q_i;
            unique case (phase_r)
              3'd0: begin
                // base = c mod m
                drem_r <= '0; dq_r <= c_r; cnt_r <= 7'(NB); phase_r <= 3'd1;
                pe_r <= ((PB+1)'(mm) + (PB+1)'(1)) >> 2;
                t1_r <= (mm == PB'(1)) ? '0 : NB'(1);
                m_r <= NB'(mm);
              end
              3'd1: begin
                if (cnt_r != 0) begin
                  logic [NB:0] t;
                  t = {drem_r[NB-1:0], dq_r[NB-1]};
                  dq_r <= {dq_r[NB-2:0], 1'b0};
                  if (t >= (NB+1)'(mm)) drem_r <= t - (NB+1)'(mm); else drem_r <= t;
                  cnt_r <= cnt_r - 7'd1;
                end else begin
                  base_r <= drem_r[NB-1:0]; phase_r <= 3'd2;
                end
              end
              3'd2: begin
                if (pe_r == '0) begin
                  if (op_r == OP_POWP) mp_r <= t1_r; else mq_r <= t1_r;
                  busy_r <= 1'b0; done_r <= 1'b1;
                end else begin
                  pinv_r <= pe_r[0];
                  a_r <= t1_r; b_r <= base_r; acc_r <= '0; cnt_r <= 7'(NB); phase_r <= 3'd3;
                end
              end
              3'd3: begin
                // acc*base if bit set
                if (cnt_r != 0) begin
                  logic [NB-1:0] t;
                  t = addm(acc_r, acc_r, m_r);
                  if (b_r[NB-1]) t = addm(t, a_r, m_r);
                  acc_r <= t; b_r <= {b_r[NB-2:0], 1'b0}; cnt_r <= cnt_r - 7'd1;
                end else begin
                  if (pinv_r) t1_r <= acc_r;
                  a_r <= base_r; b_r <= base_r; acc_r <= '0; cnt_r <= 7'(NB);
                  phase_r <= 3'd4;
                end
              end
              default: begin
                if (cnt_r != 0) begin
                  logic [NB-1:0] t;
                  t = addm(acc_r, acc_r, m_r);
                  if (b_r[NB-1]) t = addm(t, a_r, m_r);
                  acc_r <= t; b_r <= {b_r[NB-2:0], 1'b0}; cnt_r <= cnt_r - 7'd1;
                end else begin
                  base_r <= acc_r; pe_r <= pe_r >> 1; phase_r <= 3'd2;
                end
              end
            endcase
          end
          // t = (y*prime)*m mod n; CRT1 -> t1 from yp,p,mq ; CRT2 -> r1,r3 from yq,q,mp
          OP_CRT1, OP_CRT2: begin
            unique case (phase_r)
              3'd0: begin
                // y*prime < 2^NB since y < other prime; the modmul of y by prime reduces it mod n
                a_r <= (op_r == OP_CRT1) ? yp_r : yq_r;
                b_r <= (op_r == OP_CRT1) ? NB'(p_i) : NB'(q_i);
                m_r <= n_r; acc_r <= '0; cnt_r <= 7'(NB); phase_r <= 3'd1;
              end
              3'd1: begin
                if (cnt_r != 0) begin
                  logic [NB-1:0] t;
                  t = addm(acc_r, acc_r, m_r);
                  if (b_r[NB-1]) t = addm(t, a_r, m_r);
                  acc_r <= t; b_r <= {b_r[NB-2:0], 1'b0}; cnt_r <= cnt_r - 7'd1;
                end else begin
                  a_r <= acc_r; b_r <= (op_r == OP_CRT1) ? mq_r : mp_r;
                  acc_r <= '0; cnt_r <= 7'(NB); phase_r <= 3'd2;
                end
              end
              3'd2: begin
                if (cnt_r != 0) begin
                  logic [NB-1:0] t;
                  t = addm(acc_r, acc_r, m_r);
                  if (b_r[NB-1]) t = addm(t, a_r, m_r);
                  acc_r <= t; b_r <= {b_r[NB-2:0], 1'b0}; cnt_r <= cnt_r - 7'd1;
                end else begin
                  if (op_r == OP_CRT1) t1_r <= acc_r;
                  else begin
                    r1_r <= addm(t1_r, acc_r, n_r);
                    r3_r <= addm(t1_r, negm(acc_r, n_r), n_r);
                  end
                  busy_r <= 1'b0; done_r <= 1'b1;
                end
              end
              default: begin busy_r <= 1'b0; done_r <= 1'b1; end
            endcase
          end
          default: begin busy_r <= 1'b0; done_r <= 1'b1; end
        endcase
      end
    end
  end

  assign sts_o.done = done_r;
  assign sts_o.bad  = bad_r;

  always_comb begin
    unique case (sel_i)
      2'd0: res_o = 64'(r1_r);
      2'd1: res_o = 64'(negm(r1_r, n_r));
      2'd2: res_o = 64'(r3_r);
      default: res_o = 64'(negm(r3_r, n_r));
    endcase
  end
endmodule

@@ hw/rtl/rabin_ctrl.sv @@
// rabin controller: sequences datapath operations and drives the result select
module rabin_ctrl import rabin_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     cmd_i,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  dp_o,
  input  dp_sts_t  dp_i,
  output logic [1:0] sel_o,
  output logic     last_o,
  output logic     bad_o,
  output logic     take_o
);
  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   cmd_r, bad_r, bad_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic   vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; op_r <= OP_NONE; bad_r <= 1'b0; idx_r <= '0; cmd_r <= 1'b0;
    end else begin
      state_r <= state_nxt; op_r <= op_nxt; bad_r <= bad_nxt; idx_r <= idx_nxt;
      if (take_o) cmd_r <= cmd_i;
    end
  end

  assign take_o = (state_r == S_IDLE) && in_valid;

  always_comb begin
    state_nxt = state_r; op_nxt = op_r; bad_nxt = bad_r; idx_nxt = idx_r;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        state_nxt = S_START; idx_nxt = '0; bad_nxt = 1'b0;
        op_nxt = (cmd_i == CMD_ENCRYPT) ? OP_REDC : OP_INVP;
      end
      S_START: state_nxt = S_WAIT;
      S_WAIT: if (dp_i.done) begin
        state_nxt = S_START;
        unique case (op_r)
          OP_REDC: if (dp_i.bad) begin bad_nxt = 1'b1; state_nxt = S_EMIT; end
                   else if (cmd_r == CMD_ENCRYPT) op_nxt = OP_MULN;
                   else op_nxt = OP_POWP;
          OP_MULN:  state_nxt = S_EMIT;
          OP_INVP:  if (dp_i.bad) begin bad_nxt = 1'b1; state_nxt = S_EMIT; end
                    else op_nxt = OP_INVQ;
          OP_INVQ:  if (dp_i.bad) begin bad_nxt = 1'b1; state_nxt = S_EMIT; end
                    else op_nxt = OP_REDC;
          OP_POWP:  op_nxt = OP_POWQ;
          OP_POWQ:  op_nxt = OP_CRT1;
          OP_CRT1:  op_nxt = OP_CRT2;
          default:  state_nxt = S_EMIT;
        endcase
      end
      S_EMIT: state_nxt = S_HOLD;
      S_HOLD: if (!out_stall) begin
        if (last_o) state_nxt = S_IDLE;
        else begin idx_nxt = idx_r + 2'd1; state_nxt = S_EMIT; end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    dp_o.start = (state_r == S_START);
    dp_o.op    = op_r;
    vld_r      = (state_r == S_HOLD);
  end

  // n=0 shows up during redc as a zero-modulus divide; the top level flags zero primes as bad
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = vld_r;
  assign sel_o     = idx_r;
  assign bad_o     = bad_r;
  assign last_o    = bad_r || (cmd_r == CMD_ENCRYPT) || (idx_r == 2'd3);
endmodule

@@ hw/rtl/rabin_encrypt_decrypt_core.sv @@
// rabin encrypt/decrypt core top level
// decrypt run time is set by two modular powers and two euclid runs
// throughput: one request at a time; next request taken after its last result
// each further result passes through the emit and hold states and waits out any output stall
// reset: synchronous active-low; primes return to 3 and 7, controller to idle
module rabin_encrypt_decrypt_core import rabin_pkg::*; #(
  parameter int PRIME_BITS = PRIME_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_req_t         in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output out_req_t        out_data,
  input  logic            cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]     cfg_wdata
);
  // private primes
  logic [31:0] p_r, q_r;
  logic [63:0] val_r;
  dp_cmd_t dpc;
  dp_sts_t dps;
  logic [1:0] sel;
  logic last, bad, take;
  logic [63:0] res;
  logic [PRIME_BITS-1:0] pm, qm;
  logic zero_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= 32'd3; q_r <= 32'd7;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_PRIME_P: p_r <= cfg_wdata;
        default:     q_r <= cfg_wdata;
      endcase
    end
  end

  // latch request payload
  always_ff @(posedge clk) if (take) val_r <= in_data.value_in;

  assign pm = p_r[PRIME_BITS-1:0];
  assign qm = q_r[PRIME_BITS-1:0];
  // a zero prime makes n zero; any euclid run with a zero modulus is flagged bad
  assign zero_n = (pm == '0) || (qm == '0);

  dp_sts_t dps_g;
  assign dps_g.done = dps.done;
  assign dps_g.bad  = dps.bad || zero_n;

  rabin_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .cmd_i(in_data.cmd),
    .out_valid, .out_stall, .dp_o(dpc), .dp_i(dps_g),
    .sel_o(sel), .last_o(last), .bad_o(bad), .take_o(take)
  );

  rabin_dp #(.PRIME_BITS(PRIME_BITS)) u_dp (
    .clk, .rst_n, .cmd_i(dpc), .sts_o(dps), .p_i(pm), .q_i(qm),
    .val_i(val_r), .sel_i(sel), .res_o(res)
  );

  // bad key results carry zero payload
  assign out_data.value_out  = bad ? 64'd0 : res;
  assign out_data.root_index = bad ? 2'd0 : sel;
  assign out_data.last       = last;
  assign out_data.status     = bad ? ST_BAD : ST_OK;
endmodule

@@ hw/rtl/rabin_checker.sv @@
// port-level checker for the rabin core, bound to the top level
module rabin_checker import rabin_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_req_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out held");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.last && out_data.value_out == 64'd0)
    else $error("bad key result malformed");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.root_index == 2'd3 |-> out_data.last) else $error("last");
endmodule

bind rabin_encrypt_decrypt_core rabin_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);

@@ sim/rabin_encrypt_decrypt_core_tb.sv @@
// testbench for the rabin encrypt/decrypt core: random requests checked against a predictor
module rabin_encrypt_decrypt_core_tb;
  import rabin_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // scoreboard: predicts the results of each accepted request and checks them in order
  class rabin_scoreboard;
    logic [31:0] key_p = 32'd3;
    logic [31:0] key_q = 32'd7;
    out_req_t    pending_results[$];
    int          mismatches = 0;
    int          results_seen = 0;

    // exact a*b mod m via a 128-bit product
    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      prod = prod % {64'd0, m};
      return prod[63:0];
    endfunction

    function automatic logic [63:0] powmod(logic [63:0] base, logic [63:0] e, logic [63:0] m);
      logic [63:0] acc;
      acc = 64'd1 % m;
      base = base % m;
      while (e != 0) begin
        if (e[0]) acc = mulmod(acc, base, m);
        base = mulmod(base, base, m);
        e = e >> 1;
      end
      return acc;
    endfunction

    // extended euclid; returns 1 when a has an inverse mod m
    function automatic bit invmod(logic [63:0] a, logic [63:0] m, output logic [63:0] inv);
      logic [63:0] x, y, c0, c1, quo, rem, cn;
      x = a % m;
      y = m;
      c0 = 64'd1 % m;
      c1 = 64'd0;
      while (y != 0) begin
        quo = x / y;
        rem = x % y;
        cn = (c0 + m - (quo * c1) % m) % m;
        x = y;
        y = rem;
        c0 = c1;
        c1 = cn;
      end
      inv = c0;
      return x == 64'd1;
    endfunction

    function automatic void push_result(logic [63:0] v, logic [1:0] idx, logic lst, logic st);
      out_req_t r;
      r.value_out = v;
      r.root_index = idx;
      r.last = lst;
      r.status = st;
      pending_results.push_back(r);
    endfunction

    function automatic void note_request(in_req_t req);
      logic [63:0]  p, q, n, c, mp, mq, yp, yq, t1, t2, r1, r3;
      logic [127:0] sum;
      bit           ok_p, ok_q;
      p = {32'd0, key_p};
      q = {32'd0, key_q};
      n = p * q;
      // zero prime: the key is unusable for either operation
      if (n == 0) begin
        push_result(64'd0, 2'd0, 1'b1, ST_BAD);
        return;
      end
      c = req.value_in % n;
      if (req.cmd == CMD_ENCRYPT) begin
        push_result(mulmod(c, c, n), 2'd0, 1'b1, ST_OK);
        return;
      end
      ok_p = invmod(p, q, yp);
      ok_q = invmod(q, p, yq);
      // primes sharing a factor: no crt inverse
      if (!ok_p || !ok_q) begin
        push_result(64'd0, 2'd0, 1'b1, ST_BAD);
        return;
      end
      mp = powmod(c, (p + 64'd1) / 64'd4, p);
      mq = powmod(c, (q + 64'd1) / 64'd4, q);
      t1 = mulmod((yp * p) % n, mq % n, n);
      t2 = mulmod((yq * q) % n, mp % n, n);
      sum = {64'd0, t1} + {64'd0, t2};
      sum = sum % {64'd0, n};
      r1 = sum[63:0];
      sum = {64'd0, t1} + {64'd0, (n - t2) % n};
      sum = sum % {64'd0, n};
      r3 = sum[63:0];
      // negated roots wrap so a zero root stays zero
      push_result(r1, 2'd0, 1'b0, ST_OK);
      push_result((n - r1) % n, 2'd1, 1'b0, ST_OK);
      push_result(r3, 2'd2, 1'b0, ST_OK);
      push_result((n - r3) % n, 2'd3, 1'b1, ST_OK);
    endfunction

    function automatic void check_result(out_req_t got);
      out_req_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h idx %0d last %0b status %0b",
                   got.value_out, got.root_index, got.last, got.status);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch p=%0d q=%0d: want %h/%0d/%0b/%0b got %h/%0d/%0b/%0b",
                   key_p, key_q, want.value_out, want.root_index, want.last,
                   want.status, got.value_out, got.root_index, got.last, got.status);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_req_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_req_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [31:0]          cfg_wdata;

  rabin_scoreboard sb;
  int  n_encrypt = 0;
  int  n_decrypt = 0;
  int  n_keys = 1;
  bit  send_busy_mode;   // when set the sender never idles
  bit  sink_busy_mode;   // when set the receiver never stalls

  rabin_encrypt_decrypt_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the core hangs
  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stall before each result, then take it and check it
  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = sink_busy_mode ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      // stall is low from here, so the first valid edge moves a result
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
    end
  end

  // one input request with a random lead-in gap
  task automatic send_request(logic cmd, logic [63:0] value);
    int gap;
    in_req_t req;
    gap = send_busy_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.cmd = cmd;
    req.value_in = value;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    // accepted at this edge
    sb.note_request(req);
    if (cmd == CMD_ENCRYPT) n_encrypt++;
    else n_decrypt++;
  endtask

  // key change only once the core has drained every result
  task automatic load_key(logic [31:0] p, logic [31:0] q);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= REG_PRIME_P;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_idx <= REG_PRIME_Q;
    cfg_wdata <= q;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.key_p = p;
    sb.key_q = q;
    n_keys++;
  endtask

  function automatic logic [63:0] rand_value();
    // full 64-bit values half the time, otherwise 8-bit or 32-bit ones
    case ($urandom_range(0, 3))
      0: return {32'd0, $urandom_range(0, 255)};
      1: return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // random requests under the current key, mostly decrypts to reach the crt path
  task automatic random_burst(int count);
    send_busy_mode = ($urandom_range(0, 3) == 0);
    sink_busy_mode = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      if ($urandom_range(0, 2) == 0) send_request(CMD_ENCRYPT, rand_value());
      else send_request(CMD_DECRYPT, rand_value());
    end
    send_busy_mode = 1'b0;
    sink_busy_mode = 1'b0;
  endtask

  initial begin
    int limit;
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_PRIME_P;
    cfg_wdata <= '0;
    send_busy_mode = 1'b0;
    sink_busy_mode = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key 3*7: value extremes, both operations
    send_request(CMD_ENCRYPT, 64'd0);
    send_request(CMD_DECRYPT, 64'd0);
    send_request(CMD_ENCRYPT, 64'd20);
    send_request(CMD_DECRYPT, 64'd21);
    send_request(CMD_DECRYPT, 64'd4);
    send_request(CMD_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(CMD_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);

    // largest primes that are 3 mod 4
    load_key(32'd4294967291, 32'd4294967279);
    send_request(CMD_ENCRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(CMD_DECRYPT, 64'hFFFF_FFEA_0000_0075);
    send_request(CMD_DECRYPT, 64'd1);

    // zero prime makes the key invalid
    load_key(32'd0, 32'd7);
    send_request(CMD_ENCRYPT, 64'd5);
    send_request(CMD_DECRYPT, 64'd5);

    // equal primes: no inverse exists
    load_key(32'd7, 32'd7);
    send_request(CMD_DECRYPT, 64'd9);
    send_request(CMD_ENCRYPT, 64'd9);

    // modulus one collapses everything to zero
    load_key(32'd1, 32'd1);
    send_request(CMD_ENCRYPT, 64'd12345);
    send_request(CMD_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);

    // primes that are 1 mod 4: defined but not true roots
    load_key(32'd5, 32'd13);
    send_request(CMD_DECRYPT, 64'd49);
    send_request(CMD_ENCRYPT, 64'd64);
    random_burst(10);

    // random phases: small valid primes, big primes, arbitrary register values
    load_key(32'd11, 32'd19);
    random_burst(20);
    load_key(32'd4294967291, 32'd4294967279);
    random_burst(12);
    load_key(32'd65519, 32'd65539);
    random_burst(20);
    load_key($urandom, $urandom);
    random_burst(12);
    load_key($urandom_range(3, 4095), $urandom_range(3, 4095));
    random_burst(20);
    load_key(32'hFFFF_FFFF, $urandom);
    random_burst(8);

    in_valid <= 1'b0;

    // drain, then give the core time to emit anything stray
    while (sb.pending_results.size() != 0) @(posedge clk);
    limit = 0;
    while (limit < 200) begin
      @(posedge clk);
      limit++;
    end

    $display("covered %0d encrypt and %0d decrypt requests over %0d keys, %0d results checked",
             n_encrypt, n_decrypt, n_keys, sb.results_seen);
    $display("keys included zero prime, shared factor, modulus one and 32-bit extremes");
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/rabin_pkg.sv
hw/rtl/rabin_dp.sv
hw/rtl/rabin_ctrl.sv
hw/rtl/rabin_encrypt_decrypt_core.sv
hw/rtl/rabin_checker.sv
sim/rabin_encrypt_decrypt_core_tb.sv
